// ===== rtl/owbm_pkg.sv =====
package owbm_pkg;

  localparam int TickW = 10;
  localparam logic [TickW-1:0] READ_TAIL_TICKS = 10'd45;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW      = 3'd3;
  localparam logic [2:0] REG_ONE_LOW       = 3'd4;
  localparam logic [2:0] REG_ONE_TAIL      = 3'd5;
  localparam logic [2:0] REG_READ_LOW      = 3'd6;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd7;

  localparam logic [TickW-1:0] DEF_RESET_LOW     = 10'd480;
  localparam logic [TickW-1:0] DEF_PRESENCE_WAIT = 10'd60;
  localparam logic [TickW-1:0] DEF_RESET_TAIL    = 10'd420;
  localparam logic [TickW-1:0] DEF_ZERO_LOW      = 10'd60;
  localparam logic [TickW-1:0] DEF_ONE_LOW       = 10'd10;
  localparam logic [TickW-1:0] DEF_ONE_TAIL      = 10'd50;
  localparam logic [TickW-1:0] DEF_READ_LOW      = 10'd5;
  localparam logic [TickW-1:0] DEF_READ_SAMPLE   = 10'd15;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_TAIL  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8,
    PH_WR_GAP   = 4'd9,
    PH_RD_GAP   = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    DONE_NONE  = 2'd0,
    DONE_RESET = 2'd1,
    DONE_WRITE = 2'd2,
    DONE_READ  = 2'd3
  } done_t;

  typedef struct packed {
    logic [TickW-1:0] reset_low_ticks;
    logic [TickW-1:0] presence_wait_ticks;
    logic [TickW-1:0] reset_tail_ticks;
    logic [TickW-1:0] zero_low_ticks;
    logic [TickW-1:0] one_low_ticks;
    logic [TickW-1:0] one_tail_ticks;
    logic [TickW-1:0] read_low_ticks;
    logic [TickW-1:0] read_sample_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [TickW-1:0] tick_count;
    logic [2:0]       bit_index;
    logic [7:0]       shift_byte;
    logic             presence_seen;
    logic             line_enable;
    logic             line_value;
    done_t            done_kind;
  } st_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage

// ===== rtl/owbm_if.sv =====
interface owbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, output kind, output write_data, output line_level,
                  input ready);
  modport sink (input valid, input kind, input write_data, input line_level,
                output ready);
endinterface

interface owbm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_level;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, output drive_enable, output drive_level,
                  output busy_res, output done_res, output presence,
                  output read_data, output rejected, input ready);
  modport sink (input valid, input drive_enable, input drive_level,
                input busy_res, input done_res, input presence,
                input read_data, input rejected, output ready);
endinterface

// ===== rtl/owbm_step.sv =====
module owbm_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [1:0]    kind,
  input  logic [7:0]    wdata,
  input  logic          lvl,
  input  owbm_pkg::cfg_t cfg,
  output owbm_pkg::res_t res
);
  import owbm_pkg::*;

  st_t  st_r;
  st_t  st_nxt;
  logic rejected;

  function automatic logic [TickW-1:0] phase_len(st_t s, cfg_t c);
    logic [TickW-1:0] len;
    unique case (s.phase)
      PH_RST_LOW:  len = c.reset_low_ticks;
      PH_RST_WAIT: len = c.presence_wait_ticks;
      PH_RST_TAIL: len = c.reset_tail_ticks;
      PH_WR_LOW:   len = s.shift_byte[0] ? c.one_low_ticks : c.zero_low_ticks;
      PH_WR_TAIL:  len = c.one_tail_ticks;
      PH_RD_LOW:   len = c.read_low_ticks;
      PH_RD_WAIT:  len = c.read_sample_ticks;
      PH_RD_TAIL:  len = READ_TAIL_TICKS;
      default:     len = 10'd1;
    endcase
    return len;
  endfunction

  function automatic st_t slot_fin(st_t s, logic writing);
    st_t o;
    o = s;
    if (writing) o.shift_byte = {1'b0, s.shift_byte[7:1]};
    if (s.bit_index == 3'd7) begin
      o.done_kind = writing ? DONE_WRITE : DONE_READ;
      o.phase     = PH_IDLE;
      o.bit_index = 3'd0;
    end else begin
      o.bit_index = s.bit_index + 3'd1;
      o.phase     = writing ? PH_WR_GAP : PH_RD_GAP;
    end
    return o;
  endfunction

  function automatic st_t end_phase(st_t s, logic l);
    st_t o;
    o = s;
    unique case (s.phase)
      PH_RST_LOW: begin
        o.line_enable = 1'b0; o.line_value = 1'b1; o.phase = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        o.presence_seen = ~l; o.phase = PH_RST_TAIL;
      end
      PH_RST_TAIL: begin
        o.done_kind = DONE_RESET; o.phase = PH_IDLE;
      end
      PH_WR_LOW: begin
        o.line_enable = 1'b0; o.line_value = 1'b1;
        if (s.shift_byte[0]) o.phase = PH_WR_TAIL;
        else o = slot_fin(o, 1'b1);
      end
      PH_WR_TAIL: o = slot_fin(s, 1'b1);
      PH_RD_LOW: begin
        o.line_enable = 1'b0; o.line_value = 1'b1; o.phase = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        o.shift_byte = {l, s.shift_byte[7:1]}; o.phase = PH_RD_TAIL;
      end
      PH_RD_TAIL: o = slot_fin(s, 1'b0);
      PH_WR_GAP: begin
        o.line_enable = 1'b1; o.line_value = 1'b0; o.phase = PH_WR_LOW;
      end
      PH_RD_GAP: begin
        o.line_enable = 1'b1; o.line_value = 1'b0; o.phase = PH_RD_LOW;
      end
      default: begin
        o.line_enable = 1'b0; o.line_value = 1'b1; o.phase = PH_IDLE;
      end
    endcase
    o.tick_count = '0;
    return o;
  endfunction

  function automatic logic may_be_empty(phase_t p);
    return (p == PH_RST_TAIL) || (p == PH_WR_TAIL) || (p == PH_RD_WAIT);
  endfunction

  always_comb begin
    st_nxt = st_r;
    st_nxt.done_kind = DONE_NONE;
    rejected = 1'b0;
    if (kind == KIND_TICK) begin
      if (st_r.phase != PH_IDLE) begin
        st_nxt.tick_count = st_r.tick_count + 10'd1;
        if (st_nxt.tick_count >= phase_len(st_nxt, cfg)) begin
          st_nxt = end_phase(st_nxt, lvl);
          // zero-length wait or tail collapses into the same tick
          if (may_be_empty(st_nxt.phase) && (phase_len(st_nxt, cfg) == '0)) begin
            st_nxt = end_phase(st_nxt, lvl);
          end
        end
      end
    end else if (st_r.phase != PH_IDLE) begin
      rejected = 1'b1;
    end else begin
      st_nxt.tick_count  = '0;
      st_nxt.bit_index   = 3'd0;
      st_nxt.line_enable = 1'b1;
      st_nxt.line_value  = 1'b0;
      if (kind == KIND_RESET) begin
        st_nxt.presence_seen = 1'b0;
        st_nxt.phase         = PH_RST_LOW;
      end else if (kind == KIND_WRITE) begin
        st_nxt.shift_byte = wdata;
        st_nxt.phase      = PH_WR_LOW;
      end else begin
        st_nxt.shift_byte = 8'd0;
        st_nxt.phase      = PH_RD_LOW;
      end
    end
  end

  always_comb begin
    res.drive_enable = st_nxt.line_enable;
    res.drive_level  = st_nxt.line_value;
    res.busy_res     = (st_nxt.phase != PH_IDLE);
    res.done_res     = (st_nxt.done_kind != DONE_NONE);
    res.presence     = (st_nxt.done_kind == DONE_RESET) ? st_nxt.presence_seen : 1'b0;
    res.read_data    = (st_nxt.done_kind == DONE_READ) ? st_nxt.shift_byte : 8'd0;
    res.rejected     = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= PH_IDLE;
      st_r.tick_count    <= '0;
      st_r.bit_index     <= 3'd0;
      st_r.shift_byte    <= 8'd0;
      st_r.presence_seen <= 1'b0;
      st_r.line_enable   <= 1'b0;
      st_r.line_value    <= 1'b1;
      st_r.done_kind     <= DONE_NONE;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (!st_r.line_enable && st_r.line_value))
    else $error("line driven while idle");
  a_bit_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.bit_index != 3'd0) |-> (st_r.phase != PH_IDLE))
    else $error("bit index left nonzero in idle");
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.done_res) |=> (st_r.phase == PH_IDLE))
    else $error("done reported while sequence continues");
`endif

endmodule

// ===== rtl/one_wire_bus_master_unit.sv =====
// channel   dir  fields                                        accepted when
// in_req    in   kind, write_data, line_level                   valid && ready
// out_res   out  drive_enable, drive_level, busy_res, done_res, valid && ready
//                presence, read_data, rejected
// cfg (apb) in   8 x 10-bit timing regs at 4*i                  psel&&penable&&pwrite
//
// one request per clock while in_req.ready; result next cycle unless out_res stalls
// sequencer state is a single register stage updated on each accepted request
// two-entry output buffer keeps in_req.ready high through one stalled result
// rst_n synchronous: sequencer idle, line released, timing regs to defaults
module one_wire_bus_master_unit (
  input  logic        clk,
  input  logic        rst_n,
  owbm_in_if.sink     in_req,
  owbm_out_if.source  out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import owbm_pkg::*;

  cfg_t cfg_r;
  res_t step_res;
  res_t out_r;
  res_t skid_r;
  logic out_valid_r;
  logic skid_valid_r;
  logic acc;
  logic pop;
  logic wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= DEF_RESET_LOW;
      cfg_r.presence_wait_ticks <= DEF_PRESENCE_WAIT;
      cfg_r.reset_tail_ticks    <= DEF_RESET_TAIL;
      cfg_r.zero_low_ticks      <= DEF_ZERO_LOW;
      cfg_r.one_low_ticks       <= DEF_ONE_LOW;
      cfg_r.one_tail_ticks      <= DEF_ONE_TAIL;
      cfg_r.read_low_ticks      <= DEF_READ_LOW;
      cfg_r.read_sample_ticks   <= DEF_READ_SAMPLE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RESET_LOW:     cfg_r.reset_low_ticks     <= pwdata[TickW-1:0];
        REG_PRESENCE_WAIT: cfg_r.presence_wait_ticks <= pwdata[TickW-1:0];
        REG_RESET_TAIL:    cfg_r.reset_tail_ticks    <= pwdata[TickW-1:0];
        REG_ZERO_LOW:      cfg_r.zero_low_ticks      <= pwdata[TickW-1:0];
        REG_ONE_LOW:       cfg_r.one_low_ticks       <= pwdata[TickW-1:0];
        REG_ONE_TAIL:      cfg_r.one_tail_ticks      <= pwdata[TickW-1:0];
        REG_READ_LOW:      cfg_r.read_low_ticks      <= pwdata[TickW-1:0];
        REG_READ_SAMPLE:   cfg_r.read_sample_ticks   <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RESET_LOW:     prdata = {22'd0, cfg_r.reset_low_ticks};
      REG_PRESENCE_WAIT: prdata = {22'd0, cfg_r.presence_wait_ticks};
      REG_RESET_TAIL:    prdata = {22'd0, cfg_r.reset_tail_ticks};
      REG_ZERO_LOW:      prdata = {22'd0, cfg_r.zero_low_ticks};
      REG_ONE_LOW:       prdata = {22'd0, cfg_r.one_low_ticks};
      REG_ONE_TAIL:      prdata = {22'd0, cfg_r.one_tail_ticks};
      REG_READ_LOW:      prdata = {22'd0, cfg_r.read_low_ticks};
      REG_READ_SAMPLE:   prdata = {22'd0, cfg_r.read_sample_ticks};
      default:           prdata = 32'd0;
    endcase
  end

  assign in_req.ready = !skid_valid_r;
  assign acc = in_req.valid && in_req.ready;
  assign pop = out_valid_r && out_res.ready;

  owbm_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .kind  (in_req.kind),
    .wdata (in_req.write_data),
    .lvl   (in_req.line_level),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= acc;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (acc) skid_r <= step_res;
      end else if (acc) begin
        out_r <= step_res;
      end
    end else if (acc) begin
      skid_r <= step_res;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.drive_enable = out_r.drive_enable;
  assign out_res.drive_level  = out_r.drive_level;
  assign out_res.busy_res     = out_r.busy_res;
  assign out_res.done_res     = out_r.done_res;
  assign out_res.presence     = out_r.presence;
  assign out_res.read_data    = out_r.read_data;
  assign out_res.rejected     = out_r.rejected;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.busy_res) |-> (!out_r.drive_enable && out_r.drive_level))
    else $error("line driven with no sequence running");
  a_done_xor_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.done_res && out_r.rejected))
    else $error("done and rejected in one result");
`endif

endmodule
